[rtl/core/hkt_pkg.sv]
// shared types and constants for the hash key table insert/lookup unit
// no dependencies; used by hkt_cell and hash_key_table_insert_lookup_unit
package hkt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_KEY_BITS    = 64;

  localparam int KEY_FIELD_BITS  = 64;
  localparam int SLOT_FIELD_BITS = 6;
  localparam int STATUS_BITS     = 2;
  localparam int IN_DATA_BITS    = 72;
  localparam int OUT_DATA_BITS   = 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_COLLISION = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // control part of the request token that walks the cell row
  typedef struct packed {
    logic valid;
    logic lookup;
    logic hit;
    logic stored;
  } hkt_ctl_t;

endpackage

[rtl/core/hkt_cell.sv]
// one table slot: holds a stored key, compares the passing request against it
// and writes the request key when it is the next free slot; uses hkt_pkg
module hkt_cell #(
  parameter int INDEX    = 0,
  parameter int KEY_BITS = 64,
  parameter int SLOT_W   = 6,
  parameter int COUNT_W  = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [COUNT_W-1:0]   count,
  input  hkt_pkg::hkt_ctl_t    ctl_in,
  input  logic [KEY_BITS-1:0]  key_in,
  input  logic [SLOT_W-1:0]    slot_in,
  output hkt_pkg::hkt_ctl_t    ctl_out,
  output logic [KEY_BITS-1:0]  key_out,
  output logic [SLOT_W-1:0]    slot_out
);
  import hkt_pkg::*;

  logic [KEY_BITS-1:0] stored_key;
  logic                occupied;
  logic                match;
  logic                write_en;
  hkt_ctl_t            ctl_next;
  logic [SLOT_W-1:0]   slot_next;

  assign occupied = count > COUNT_W'(INDEX);
  assign match    = ctl_in.valid && !ctl_in.hit && occupied && (stored_key == key_in);
  // all occupied slots lie before this one, so no hit can come later
  assign write_en = ctl_in.valid && (ctl_in.lookup == REQ_INSERT) && !ctl_in.hit
                    && (count == COUNT_W'(INDEX));

  always_comb begin
    ctl_next  = ctl_in;
    slot_next = slot_in;
    if (match) begin
      ctl_next.hit = 1'b1;
      slot_next    = SLOT_W'(INDEX);
    end
    if (write_en) begin
      ctl_next.stored = 1'b1;
      slot_next       = SLOT_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      stored_key <= key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    key_out  <= key_in;
    slot_out <= slot_next;
  end

endmodule

[rtl/core/hash_key_table_insert_lookup_unit.sv]
// Hash key table with insert and lookup requests, built as a row of
// TABLE_DEPTH slot cells. A request walks the row one cell per cycle; each
// cell compares its stored key, and on an insert the first free cell takes
// the key. One request is in the row at a time: its result passes from
// the last cell through the done register to the output register, and
// the next request is taken once that result has moved to the output
// register, so the cost of a request is set by the length of the cell row.
// Status: 0 ok or found, 1 not found, 2 duplicate key, 3 table full.
// Depends on hkt_pkg and hkt_cell.
module hash_key_table_insert_lookup_unit #(
  parameter int TABLE_DEPTH = hkt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_BITS    = hkt_pkg::DEFAULT_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] req_type, [64:1] key, [71:65] zero
  input  logic [hkt_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [7:2] slot_index
  output logic [hkt_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
  import hkt_pkg::*;

  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  hkt_ctl_t            ctl_c  [0:TABLE_DEPTH];
  logic [KEY_BITS-1:0] key_c  [0:TABLE_DEPTH];
  logic [SLOT_W-1:0]   slot_c [0:TABLE_DEPTH];

  logic                busy;
  logic [COUNT_W-1:0]  count;
  logic                accept;
  logic                done_valid;
  status_t             done_status;
  logic [SLOT_W-1:0]   done_slot;
  logic                move;
  status_t             end_status;
  logic [SLOT_W-1:0]   end_slot;
  logic [SLOT_W+SLOT_FIELD_BITS-1:0] slot_wide;
  logic                out_valid;
  status_t             out_status;
  logic [SLOT_FIELD_BITS-1:0] out_slot;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign move          = done_valid && (!out_valid || m_axis_tready);

  always_comb begin
    ctl_c[0]        = '0;
    ctl_c[0].valid  = accept;
    ctl_c[0].lookup = s_axis_tdata[0];
  end
  assign key_c[0]  = s_axis_tdata[KEY_BITS:1];
  assign slot_c[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hkt_cell #(
      .INDEX   (i),
      .KEY_BITS(KEY_BITS),
      .SLOT_W  (SLOT_W),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .ctl_in  (ctl_c[i]),
      .key_in  (key_c[i]),
      .slot_in (slot_c[i]),
      .ctl_out (ctl_c[i+1]),
      .key_out (key_c[i+1]),
      .slot_out(slot_c[i+1])
    );
  end

  // result of the token leaving the last cell
  always_comb begin
    end_status = ST_OK;
    end_slot   = slot_c[TABLE_DEPTH];
    if (ctl_c[TABLE_DEPTH].lookup == REQ_LOOKUP) begin
      if (!ctl_c[TABLE_DEPTH].hit) begin
        end_status = ST_NOT_FOUND;
        end_slot   = '0;
      end
    end else if (ctl_c[TABLE_DEPTH].hit) begin
      end_status = ST_COLLISION;
      end_slot   = '0;
    end else if (!ctl_c[TABLE_DEPTH].stored) begin
      end_status = ST_FULL;
      end_slot   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      count      <= '0;
      done_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (ctl_c[TABLE_DEPTH].valid && ctl_c[TABLE_DEPTH].stored) begin
        count <= count + COUNT_W'(1);
      end
      if (ctl_c[TABLE_DEPTH].valid) begin
        done_valid <= 1'b1;
      end else if (move) begin
        done_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign slot_wide = {{SLOT_FIELD_BITS{1'b0}}, done_slot};

  always_ff @(posedge clk) begin
    if (ctl_c[TABLE_DEPTH].valid) begin
      done_status <= end_status;
      done_slot   <= end_slot;
    end
    if (move) begin
      out_status <= done_status;
      out_slot   <= slot_wide[SLOT_FIELD_BITS-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_slot, out_status};

endmodule

[tb/hash_key_table_insert_lookup_unit_tb.sv]
// testbench for hash_key_table_insert_lookup_unit: directed and random insert/lookup requests,
// each reply checked against a local model of the key table
// depends on hkt_pkg and the unit rtl
module hash_key_table_insert_lookup_unit_tb;
  import hkt_pkg::*;

  localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int KEY_BITS = DEFAULT_KEY_BITS;
  localparam logic [KEY_FIELD_BITS-1:0] KEY_MASK = {KEY_FIELD_BITS{1'b1}} >> (64 - KEY_BITS);
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    status_t status;
    logic [SLOT_FIELD_BITS-1:0] slot;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  // model of the key table
  logic [KEY_FIELD_BITS-1:0] table_keys[TABLE_DEPTH];
  int unsigned table_count = 0;
  table_reply_t pending_replies[$];

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int fail_count = 0;

  hash_key_table_insert_lookup_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // scan from slot 0 upward, append on an insert miss when there is room
  function automatic table_reply_t resolve_request(logic lookup, logic [KEY_FIELD_BITS-1:0] key);
    table_reply_t reply;
    logic [KEY_FIELD_BITS-1:0] k;
    int hit_slot;
    k = key & KEY_MASK;
    hit_slot = -1;
    for (int i = 0; i < table_count; i++) begin
      if (hit_slot < 0 && table_keys[i] == k) hit_slot = i;
    end
    reply.slot = '0;
    if (lookup == REQ_LOOKUP) begin
      if (hit_slot >= 0) begin
        reply.status = ST_OK;
        reply.slot = hit_slot[SLOT_FIELD_BITS-1:0];
      end else begin
        reply.status = ST_NOT_FOUND;
      end
    end else if (hit_slot >= 0) begin
      reply.status = ST_COLLISION;
    end else if (table_count >= TABLE_DEPTH) begin
      reply.status = ST_FULL;
    end else begin
      table_keys[table_count] = k;
      reply.status = ST_OK;
      reply.slot = table_count[SLOT_FIELD_BITS-1:0];
      table_count++;
    end
    return reply;
  endfunction

  function automatic logic [KEY_FIELD_BITS-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KEY_FIELD_BITS-1:0] stored_key();
    return table_keys[$urandom_range(table_count - 1)];
  endfunction

  // a stored key (a random one while the table is empty) with one random bit flipped, to exercise the compare
  function automatic logic [KEY_FIELD_BITS-1:0] near_miss_key();
    logic [KEY_FIELD_BITS-1:0] k;
    k = (table_count > 0) ? stored_key() : random_key();
    k[$urandom_range(KEY_FIELD_BITS - 1)] ^= 1'b1;
    return k;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(input logic lookup, input logic [KEY_FIELD_BITS-1:0] key);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_BITS - KEY_FIELD_BITS - 1){1'b0}}, key, lookup};
    do @(posedge clk); while (!s_axis_tready);
    pending_replies.push_back(resolve_request(lookup, key));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected reply status %0d slot %0d", $time,
                 m_axis_tdata[1:0], m_axis_tdata[7:2]);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[7:2] !== want.slot) begin
          fail_count++;
          $display("%0t: reply mismatch, expected status %0d slot %0d, got status %0d slot %0d",
                   $time, want.status, want.slot, m_axis_tdata[1:0], m_axis_tdata[7:2]);
        end
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_request(REQ_LOOKUP, 64'h0);
    send_request(REQ_INSERT, 64'h0);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_INSERT, 64'h8000_0000_0000_0001);
    send_request(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_LOOKUP, 64'h0);
    send_request(REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(REQ_INSERT, 64'h0);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_LOOKUP, 64'h1);
  endtask

  // mostly new keys until every slot is taken
  task automatic test_fill_table();
    int r;
    while (table_count < TABLE_DEPTH) begin
      r = $urandom_range(99);
      if (r < 45) send_request(REQ_INSERT, random_key());
      else if (r < 55) send_request(REQ_INSERT, near_miss_key());
      else if (r < 65) send_request(REQ_INSERT, stored_key());
      else if (r < 85) send_request(REQ_LOOKUP, stored_key());
      else if (r < 93) send_request(REQ_LOOKUP, near_miss_key());
      else send_request(REQ_LOOKUP, random_key());
    end
  endtask

  task automatic test_full_table();
    send_request(REQ_INSERT, near_miss_key());
    send_request(REQ_INSERT, table_keys[TABLE_DEPTH-1]);
    send_request(REQ_LOOKUP, table_keys[TABLE_DEPTH-1]);
    send_request(REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(REQ_LOOKUP, 64'h0);
  endtask

  task automatic test_random_mix(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) send_request(REQ_LOOKUP, stored_key());
      else if (r < 50) send_request(REQ_LOOKUP, near_miss_key());
      else if (r < 65) send_request(REQ_LOOKUP, random_key());
      else if (r < 80) send_request(REQ_INSERT, stored_key());
      else if (r < 90) send_request(REQ_INSERT, near_miss_key());
      else send_request(REQ_INSERT, random_key());
    end
  endtask

  initial begin
    int waited;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 6;
    receiver_idle_pct = 86;
    test_empty_and_extremes();
    test_fill_table();
    test_full_table();
    test_random_mix(RANDOM_ITEMS / 3);
    sender_idle_pct = 86;
    receiver_idle_pct = 6;
    test_random_mix(RANDOM_ITEMS / 3);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_mix(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_replies.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_replies.size() != 0) fail_count++;
    // any stray reply after the last one counts as a failure
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
